>>> rtl/btpg_pkg.sv
// Package for the beamlet test pattern generator: codes, pipeline structs and tables.
`timescale 1ns / 1ps

package btpg_pkg;

    // Bit mode codes.
    localparam logic [1:0] MODE_16  = 2'd0;
    localparam logic [1:0] MODE_8   = 2'd1;
    localparam logic [1:0] MODE_4   = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    // Beamlet numbers that carry patterns.
    localparam logic [7:0] BL_COUNT_A = 8'd2;
    localparam logic [7:0] BL_ROT_FWD = 8'd3;
    localparam logic [7:0] BL_ROT_BWD = 8'd4;
    localparam logic [7:0] BL_ONES    = 8'd5;
    localparam logic [7:0] BL_RE_ONE  = 8'd6;
    localparam logic [7:0] BL_IM_ONE  = 8'd7;
    localparam logic [7:0] BL_SINGLE  = 8'd8;
    localparam logic [7:0] BL_ZERO    = 8'd9;
    localparam logic [7:0] BL_LAG     = 8'd10;
    localparam logic [7:0] BL_CONJ    = 8'd11;
    localparam logic [7:0] BL_TONE8   = 8'd12;
    localparam logic [7:0] BL_TONE16  = 8'd13;
    localparam logic [7:0] BL_COUNT_B = 8'd14;

    typedef enum logic [3:0] {
        K_NONE,
        K_COUNT,
        K_ROT,
        K_ONES,
        K_RE_ONE,
        K_IM_ONE,
        K_SINGLE,
        K_ZERO,
        K_TONE
    } t_kind;

    // Decoded request, held in the first pipeline register.
    typedef struct packed {
        t_kind      kind;
        logic [1:0] mode;
        logic [7:0] block;
        logic [1:0] ix;
        logic [1:0] iy;
        logic       yconj;
        logic [3:0] tone_idx;
        logic       has_pattern;
        logic       mode_error;
    } t_dec;

    // Sample values, held in the second pipeline register.
    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         block;
        logic               is_count;
        logic               has_pattern;
        logic               mode_error;
        logic signed [15:0] x_re;
        logic signed [15:0] x_im;
        logic signed [15:0] y_re;
        logic signed [15:0] y_im;
    } t_val;

    // Cosine over sixteen steps of a turn, one row per mode; the fourth row is unused.
    localparam logic signed [15:0] TONE_COS [4][16] = '{
        '{16'sd32767, 16'sd30273, 16'sd23170, 16'sd12539, 16'sd0, -16'sd12539,
          -16'sd23170, -16'sd30273, -16'sd32767, -16'sd30273, -16'sd23170,
          -16'sd12539, 16'sd0, 16'sd12539, 16'sd23170, 16'sd30273},
        '{16'sd127, 16'sd117, 16'sd90, 16'sd49, 16'sd0, -16'sd49, -16'sd90,
          -16'sd117, -16'sd127, -16'sd117, -16'sd90, -16'sd49, 16'sd0, 16'sd49,
          16'sd90, 16'sd117},
        '{16'sd7, 16'sd6, 16'sd5, 16'sd3, 16'sd0, -16'sd3, -16'sd5, -16'sd6,
          -16'sd7, -16'sd6, -16'sd5, -16'sd3, 16'sd0, 16'sd3, 16'sd5, 16'sd6},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
          16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };

    // Quarter-turn rotation starting at 1+0j.
    function automatic logic signed [15:0] rot_re(input logic [1:0] idx);
        logic signed [15:0] r;
        case (idx)
            2'd0:    r = 16'sd1;
            2'd2:    r = -16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] rot_im(input logic [1:0] idx);
        logic signed [15:0] r;
        case (idx)
            2'd1:    r = 16'sd1;
            2'd3:    r = -16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/btpg_value.sv
// Sample value lookup: turns a decoded request into the four signed sample parts.
`timescale 1ns / 1ps

module btpg_value (
    input  btpg_pkg::t_dec i_dec,
    output btpg_pkg::t_val o_val
);

    logic [3:0] tone_im_idx;

    // Sine is the cosine a quarter turn earlier.
    assign tone_im_idx = i_dec.tone_idx + 4'd12;

    always_comb begin
        o_val.mode        = i_dec.mode;
        o_val.block       = i_dec.block;
        o_val.is_count    = (i_dec.kind == btpg_pkg::K_COUNT);
        o_val.has_pattern = i_dec.has_pattern;
        o_val.mode_error  = i_dec.mode_error;
        o_val.x_re        = 16'sd0;
        o_val.x_im        = 16'sd0;
        o_val.y_re        = 16'sd0;
        o_val.y_im        = 16'sd0;
        case (i_dec.kind)
            btpg_pkg::K_COUNT: begin
                if (i_dec.mode == btpg_pkg::MODE_8) begin
                    o_val.x_re = {{8{i_dec.block[7]}}, i_dec.block};
                end else begin
                    o_val.x_re = {8'd0, i_dec.block};
                end
                o_val.x_im = o_val.x_re;
                o_val.y_re = o_val.x_re;
                o_val.y_im = o_val.x_re;
            end
            btpg_pkg::K_ROT: begin
                o_val.x_re = btpg_pkg::rot_re(i_dec.ix);
                o_val.x_im = btpg_pkg::rot_im(i_dec.ix);
                o_val.y_re = btpg_pkg::rot_re(i_dec.iy);
                if (i_dec.yconj) begin
                    o_val.y_im = -btpg_pkg::rot_im(i_dec.iy);
                end else begin
                    o_val.y_im = btpg_pkg::rot_im(i_dec.iy);
                end
            end
            btpg_pkg::K_ONES: begin
                o_val.x_re = 16'sd1;
                o_val.x_im = 16'sd1;
                o_val.y_re = 16'sd1;
                o_val.y_im = 16'sd1;
            end
            btpg_pkg::K_RE_ONE: begin
                o_val.x_re = 16'sd1;
                o_val.y_re = 16'sd1;
            end
            btpg_pkg::K_IM_ONE: begin
                o_val.x_im = 16'sd1;
                o_val.y_im = 16'sd1;
            end
            btpg_pkg::K_SINGLE: begin
                // The packed mode puts the one in the real nibble of X.
                if (i_dec.mode == btpg_pkg::MODE_4) begin
                    o_val.x_re = 16'sd1;
                end else begin
                    o_val.x_im = 16'sd1;
                end
            end
            btpg_pkg::K_TONE: begin
                o_val.x_re = btpg_pkg::TONE_COS[i_dec.mode][i_dec.tone_idx];
                o_val.x_im = btpg_pkg::TONE_COS[i_dec.mode][tone_im_idx];
                o_val.y_re = o_val.x_re;
                o_val.y_im = o_val.x_im;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/beamlet_test_pattern_generator_top.sv
// Beamlet test pattern generator: decode, value and format pipeline with handshakes.
`timescale 1ns / 1ps

// Each request (beamlet, block) yields one dual-polarisation test sample under the
// bit mode register. The block takes one request per clock cycle while the output
// is not stalled, through three register stages: decode, value lookup and output
// formatting. The decode stage captures a request at the edge that accepts it, and
// its result passes through the value and format registers to the outputs.
// Every stage has its own valid bit and advances whenever the stage after it is
// empty or moving, so a stall at the output backs up one stage at a time. The bit
// mode is sampled when a request is accepted.
module beamlet_test_pattern_generator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_beamlet,
    input  logic [7:0]         i_block,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_x_re,
    output logic signed [15:0] o_x_im,
    output logic signed [15:0] o_y_re,
    output logic signed [15:0] o_y_im,
    output logic [7:0]         o_x_byte,
    output logic [7:0]         o_y_byte,
    output logic               o_has_pattern,
    output logic               o_mode_error
);

    logic [1:0]     r_bit_mode;
    logic           r_v1, r_v2, r_v3;
    logic           en1, en2, en3;
    btpg_pkg::t_dec n_dec, r_dec;
    btpg_pkg::t_val n_val, r_val;

    logic signed [15:0] n_x_re, n_x_im, n_y_re, n_y_im;
    logic [7:0]         n_x_byte, n_y_byte;
    logic               n_has_pattern, n_mode_error;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_mode <= btpg_pkg::MODE_16;
        end else if (i_cfg_we) begin
            r_bit_mode <= i_cfg_data;
        end
    end

    // Decode stage.
    always_comb begin
        n_dec             = '0;
        n_dec.kind        = btpg_pkg::K_NONE;
        n_dec.mode        = r_bit_mode;
        n_dec.block       = i_block;
        n_dec.ix          = i_block[1:0];
        n_dec.iy          = i_block[1:0];
        n_dec.yconj       = 1'b0;
        n_dec.tone_idx    = i_block[3:0];
        n_dec.mode_error  = (r_bit_mode == btpg_pkg::MODE_BAD);
        case (i_beamlet)
            btpg_pkg::BL_COUNT_A, btpg_pkg::BL_COUNT_B: n_dec.kind = btpg_pkg::K_COUNT;
            btpg_pkg::BL_ROT_FWD: n_dec.kind = btpg_pkg::K_ROT;
            btpg_pkg::BL_ROT_BWD: begin
                n_dec.kind = btpg_pkg::K_ROT;
                n_dec.ix   = 2'd0 - i_block[1:0];
                n_dec.iy   = 2'd0 - i_block[1:0];
            end
            btpg_pkg::BL_ONES:   n_dec.kind = btpg_pkg::K_ONES;
            btpg_pkg::BL_RE_ONE: n_dec.kind = btpg_pkg::K_RE_ONE;
            btpg_pkg::BL_IM_ONE: n_dec.kind = btpg_pkg::K_IM_ONE;
            btpg_pkg::BL_SINGLE: n_dec.kind = btpg_pkg::K_SINGLE;
            btpg_pkg::BL_ZERO:   n_dec.kind = btpg_pkg::K_ZERO;
            btpg_pkg::BL_LAG: begin
                n_dec.kind = btpg_pkg::K_ROT;
                n_dec.iy   = i_block[1:0] + 2'd3;
            end
            btpg_pkg::BL_CONJ: begin
                n_dec.kind  = btpg_pkg::K_ROT;
                n_dec.yconj = 1'b1;
            end
            btpg_pkg::BL_TONE8: begin
                n_dec.kind     = btpg_pkg::K_TONE;
                n_dec.tone_idx = {i_block[2:0], 1'b0};
            end
            btpg_pkg::BL_TONE16: n_dec.kind = btpg_pkg::K_TONE;
            default:             n_dec.kind = btpg_pkg::K_NONE;
        endcase
        if (n_dec.mode_error) begin
            n_dec.kind = btpg_pkg::K_NONE;
        end
        n_dec.has_pattern = (n_dec.kind != btpg_pkg::K_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_dec <= n_dec;
        end
    end

    // Value stage.
    btpg_value u_value (
        .i_dec (r_dec),
        .o_val (n_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_val <= n_val;
        end
    end

    // Format stage.
    always_comb begin
        n_x_re        = 16'sd0;
        n_x_im        = 16'sd0;
        n_y_re        = 16'sd0;
        n_y_im        = 16'sd0;
        n_x_byte      = 8'd0;
        n_y_byte      = 8'd0;
        n_has_pattern = r_val.has_pattern;
        n_mode_error  = r_val.mode_error;
        if (r_val.has_pattern) begin
            if (r_val.mode == btpg_pkg::MODE_4) begin
                // The count pattern gives the whole block index in both bytes.
                if (r_val.is_count) begin
                    n_x_byte = r_val.block;
                    n_y_byte = r_val.block;
                end else begin
                    n_x_byte = {r_val.x_im[3:0], r_val.x_re[3:0]};
                    n_y_byte = {r_val.y_im[3:0], r_val.y_re[3:0]};
                end
            end else begin
                n_x_re = r_val.x_re;
                n_x_im = r_val.x_im;
                n_y_re = r_val.y_re;
                n_y_im = r_val.y_im;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            o_x_re        <= n_x_re;
            o_x_im        <= n_x_im;
            o_y_re        <= n_y_re;
            o_y_im        <= n_y_im;
            o_x_byte      <= n_x_byte;
            o_y_byte      <= n_y_byte;
            o_has_pattern <= n_has_pattern;
            o_mode_error  <= n_mode_error;
        end
    end

endmodule
